### design/rnf_pkg.sv
// Package for the RSSI noise floor median block: sizes, codes, shared types.
// Used by the channel interfaces and by every module of the block.
package rnf_pkg;

   localparam int SAMPLES_PER_BLOCK = 64;
   localparam int CNT_W             = $clog2(SAMPLES_PER_BLOCK + 1);
   localparam int MED_LO            = SAMPLES_PER_BLOCK / 2 - 1;
   localparam int MED_HI            = SAMPLES_PER_BLOCK / 2;

   typedef logic signed [8:0]  sample_type;
   typedef logic [CNT_W-1:0]   count_type;

   localparam sample_type FLOOR_MIN = -9'sd120;

   typedef enum logic [1:0] {
      ACT_SAMPLE    = 2'd0,
      ACT_RECAL     = 2'd1,
      ACT_AGC_RESET = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_MAX_RISE  = 2'd1,
      REG_MAX_HELD  = 2'd2,
      REG_INTERVAL  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic [6:0]  interference_threshold;
      logic [6:0]  max_rise_db;
      logic [3:0]  max_held_blocks;
      logic [15:0] sample_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic       ins_en;
      logic       occupied;
      logic       tail;
   } cell_ctl_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] now_ms;
      sample_type  rssi_dbm;
      logic        radio_in_rx;
      logic        packet_in_progress;
      logic        irq_pending;
   } item_type;

endpackage

### design/rnf_if.sv
// Channel interfaces of the noise floor block: request, response, register write.
// Depends on rnf_pkg.
interface rnf_req_if import rnf_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] now_ms;
   sample_type  rssi_dbm;
   logic        radio_in_rx;
   logic        packet_in_progress;
   logic        irq_pending;

   modport source (output valid, action, now_ms, rssi_dbm, radio_in_rx,
                   packet_in_progress, irq_pending, input ready);
   modport sink   (input valid, action, now_ms, rssi_dbm, radio_in_rx,
                   packet_in_progress, irq_pending, output ready);
endinterface

interface rnf_rsp_if import rnf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type floor_dbm;
   logic       sample_taken;
   logic       block_published;
   logic       block_held;
   logic       channel_busy;
   logic [6:0] samples_in_block;

   modport source (output valid, floor_dbm, sample_taken, block_published, block_held,
                   channel_busy, samples_in_block, input ready);
   modport sink   (input valid, floor_dbm, sample_taken, block_published, block_held,
                   channel_busy, samples_in_block, output ready);
endinterface

interface rnf_csr_if import rnf_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

### design/rnf_csr.sv
// Configuration registers of the noise floor block, written one beat at a time.
// Depends on rnf_pkg and rnf_csr_if.
module rnf_csr import rnf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rnf_csr_if.sink       csr_ch,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (reg_index_type'(csr_ch.index))
            REG_THRESHOLD: cfg_in.interference_threshold = csr_ch.wdata[6:0];
            REG_MAX_RISE:  cfg_in.max_rise_db            = csr_ch.wdata[6:0];
            REG_MAX_HELD:  cfg_in.max_held_blocks        = csr_ch.wdata[3:0];
            REG_INTERVAL:  cfg_in.sample_interval_ms     = csr_ch.wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interference_threshold <= 7'd0;
         cfg_ff.max_rise_db            <= 7'd10;
         cfg_ff.max_held_blocks        <= 4'd4;
         cfg_ff.sample_interval_ms     <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/rnf_sort_cell.sv
// One cell of the sorted sample row: holds one sample and shifts it up on insert.
// Depends on rnf_pkg.
module rnf_sort_cell import rnf_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  sample_type   key,
   input  logic         prev_gt,
   input  sample_type   prev_val,
   output logic         gt,
   output sample_type   val
);

   sample_type val_ff;
   sample_type val_in;

   // cells above the key move up one place; the first of them takes the key
   assign gt  = ctl.occupied && (val_ff > key);
   assign val = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctl.ins_en) begin
         if (prev_gt) begin
            val_in = prev_val;
         end else if (gt || ctl.tail) begin
            val_in = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

### design/rssi_noise_floor_median_core.sv
// Top level of the RSSI noise floor median block: control, sorted cell row, result.
// Depends on rnf_pkg, rnf_if, rnf_csr and rnf_sort_cell.
//
//   port    dir  role
//   req_ch  in   one beat per tick: action, time, RSSI, radio status
//   rsp_ch  out  one beat per tick: floor, flags, sample count
//   csr_ch  in   register writes, index 0..3
//
// For each item the beat is registered first; then the cell row
// inserts the sample and the control state updates while the result loads.
// The next beat is taken as soon as the result register holds the answer,
// even if rsp_ch has not yet taken it; a full result register stalls the
// execute step. Reset is synchronous and clears all control state; the
// sample cells carry no reset and are read only below the sample count.
module rssi_noise_floor_median_core import rnf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   rnf_req_if.sink  req_ch,
   rnf_rsp_if.source rsp_ch,
   rnf_csr_if.sink  csr_ch
);

   cfg_type    cfg;
   state_type  state_ff, state_in;
   item_type   item_ff;
   count_type  count_ff, count_in;
   logic       consumed_ff, consumed_in;
   sample_type floor_ff, floor_in;
   logic [3:0] held_ff, held_in;
   logic [31:0] last_ff, last_in;
   sample_type median_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       taken_ff, pub_ff, heldf_ff, busy_ff;
   logic       taken, pub, heldf, busy;

   logic       go, full, ins_en;
   logic signed [9:0] med_sum, med_adj, rise_lim, busy_lim;
   sample_type med_clamped;
   logic       high;
   logic [3:0] held_inc;
   logic [31:0] elapsed;

   sample_type   cell_val [SAMPLES_PER_BLOCK];
   logic         cell_gt  [SAMPLES_PER_BLOCK];
   cell_ctl_type cell_ctl [SAMPLES_PER_BLOCK];

   rnf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   for (genvar g = 0; g < SAMPLES_PER_BLOCK; g++) begin : g_cell
      logic       prev_gt;
      sample_type prev_val;
      if (g == 0) begin : g_head
         assign prev_gt  = 1'b0;
         assign prev_val = item_ff.rssi_dbm;
      end else begin : g_body
         assign prev_gt  = cell_gt[g-1];
         assign prev_val = cell_val[g-1];
      end
      assign cell_ctl[g].ins_en   = ins_en;
      assign cell_ctl[g].occupied = count_ff > CNT_W'(g);
      assign cell_ctl[g].tail     = count_ff == CNT_W'(g);

      rnf_sort_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[g]),
         .key      (item_ff.rssi_dbm),
         .prev_gt  (prev_gt),
         .prev_val (prev_val),
         .gt       (cell_gt[g]),
         .val      (cell_val[g])
      );
   end

   // median of the two middle cells, halved toward zero
   assign med_sum = 10'(cell_val[MED_LO]) + 10'(cell_val[MED_HI]);
   assign med_adj = med_sum + $signed({9'd0, med_sum[9]});

   assign req_ch.ready = state_ff[0];
   assign go           = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ch.ready);
   assign full         = count_ff >= CNT_W'(SAMPLES_PER_BLOCK);
   assign elapsed      = item_ff.now_ms - last_ff;
   assign rise_lim     = 10'(floor_ff) + $signed({3'd0, cfg.max_rise_db});
   assign high         = 10'(median_ff) > rise_lim;
   assign med_clamped  = (median_ff < FLOOR_MIN) ? FLOOR_MIN : median_ff;
   assign held_inc     = held_ff + 4'd1;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      consumed_in = consumed_ff;
      floor_in    = floor_ff;
      held_in     = held_ff;
      last_in     = last_ff;
      taken       = 1'b0;
      pub         = 1'b0;
      heldf       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (action_type'(item_ff.action))
                  ACT_SAMPLE: begin
                     if (item_ff.radio_in_rx && !full) begin
                        if (!item_ff.packet_in_progress && (count_ff == '0 ||
                            elapsed >= {16'd0, cfg.sample_interval_ms})) begin
                           taken    = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                           last_in  = item_ff.now_ms;
                        end
                     end else if (full && !consumed_ff) begin
                        consumed_in = 1'b1;
                        if (high && held_inc < cfg.max_held_blocks) begin
                           held_in = held_inc;
                           heldf   = 1'b1;
                        end else begin
                           held_in  = 4'd0;
                           floor_in = med_clamped;
                           pub      = 1'b1;
                        end
                     end
                  end
                  ACT_RECAL: begin
                     if (full && consumed_ff) begin
                        count_in    = '0;
                        consumed_in = 1'b0;
                     end
                  end
                  ACT_AGC_RESET: begin
                     if (!item_ff.irq_pending && !item_ff.packet_in_progress) begin
                        count_in    = '0;
                        consumed_in = 1'b0;
                        held_in     = 4'd0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign ins_en   = taken;
   assign busy_lim = 10'(floor_in) + $signed({3'd0, cfg.interference_threshold});
   assign busy     = (cfg.interference_threshold != 7'd0) &&
                     (10'(item_ff.rssi_dbm) > busy_lim);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         consumed_ff  <= 1'b0;
         floor_ff     <= '0;
         held_ff      <= 4'd0;
         last_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         consumed_ff  <= consumed_in;
         floor_ff     <= floor_in;
         held_ff      <= held_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= med_adj[9:1];
      if (req_ch.valid && req_ch.ready) begin
         item_ff.action             <= req_ch.action;
         item_ff.now_ms             <= req_ch.now_ms;
         item_ff.rssi_dbm           <= req_ch.rssi_dbm;
         item_ff.radio_in_rx        <= req_ch.radio_in_rx;
         item_ff.packet_in_progress <= req_ch.packet_in_progress;
         item_ff.irq_pending        <= req_ch.irq_pending;
      end
      if (go) begin
         taken_ff <= taken;
         pub_ff   <= pub;
         heldf_ff <= heldf;
         busy_ff  <= busy;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.floor_dbm        = floor_ff;
   assign rsp_ch.sample_taken     = taken_ff;
   assign rsp_ch.block_published  = pub_ff;
   assign rsp_ch.block_held       = heldf_ff;
   assign rsp_ch.channel_busy     = busy_ff;
   assign rsp_ch.samples_in_block = 7'(count_ff);

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SAMPLES_PER_BLOCK))
      else $error("sample count beyond block size");

   a_floor_min: assert property (@(posedge clock) disable iff (reset)
      floor_ff >= FLOOR_MIN)
      else $error("published floor below clamp");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == S_EXEC)
      else $error("accepted beat not executed");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(taken_ff && (pub_ff || heldf_ff)) && !(pub_ff && heldf_ff))
      else $error("conflicting result flags");
`endif

endmodule

### tb/rssi_noise_floor_median_core_tb.sv
// Self-checking testbench for rssi_noise_floor_median_core: directed ticks, then
// random phases under several register settings, each result checked against its table row or a predictor.
// Depends on rnf_pkg, rnf_if and the core itself.
module rssi_noise_floor_median_core_tb;
   import rnf_pkg::*;

   localparam int MAX_WAIT       = 8;
   localparam int TICKS_PER_PHASE = 255;
   localparam int NUM_PHASES     = 6;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      sample_type floor_dbm;
      logic       sample_taken;
      logic       block_published;
      logic       block_held;
      logic       channel_busy;
      logic [6:0] samples_in_block;
   } floor_rsp_type;

   typedef struct packed {
      item_type      tick;
      logic          typed;
      floor_rsp_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   rnf_req_if req_ch ();
   rnf_rsp_if rsp_ch ();
   rnf_csr_if csr_ch ();

   rssi_noise_floor_median_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   cfg_type     cfg_q;
   sample_type  sorted_q [SAMPLES_PER_BLOCK];
   int          count_q;
   logic        consumed_q;
   int          floor_q;
   logic [3:0]  held_q;
   logic [31:0] last_ms_q;

   floor_rsp_type pending_results [$];
   dir_row_type   dir_rows [$];
   int            err_cnt = 0;
   int            rsp_idx = 0;
   bit            quiet;

   // stimulus shaping
   logic [31:0] clock_ms;
   int          block_level;
   int          block_spread;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic floor_rsp_type predict_floor_result(item_type t);
      floor_rsp_type r;
      int            rssi;
      int            median;
      int            j;
      logic [31:0]   elapsed;
      bit            hold;
      r = '0;
      rssi = $signed(t.rssi_dbm);
      case (action_type'(t.action))
         ACT_SAMPLE: begin
            elapsed = t.now_ms - last_ms_q;
            if (t.radio_in_rx && count_q < SAMPLES_PER_BLOCK) begin
               if (!t.packet_in_progress &&
                   (count_q == 0 || elapsed >= {16'd0, cfg_q.sample_interval_ms})) begin
                  j = count_q;
                  while (j > 0 && int'(sorted_q[j-1]) > rssi) begin
                     sorted_q[j] = sorted_q[j-1];
                     j--;
                  end
                  sorted_q[j] = t.rssi_dbm;
                  count_q++;
                  last_ms_q = t.now_ms;
                  r.sample_taken = 1'b1;
               end
            end else if (count_q >= SAMPLES_PER_BLOCK && !consumed_q) begin
               consumed_q = 1'b1;
               median = (int'(sorted_q[MED_LO]) + int'(sorted_q[MED_HI])) / 2;
               hold = 1'b0;
               if (median > floor_q + int'(cfg_q.max_rise_db)) begin
                  held_q = held_q + 4'd1;
                  hold = (held_q < cfg_q.max_held_blocks);
               end
               if (hold) begin
                  r.block_held = 1'b1;
               end else begin
                  held_q = '0;
                  floor_q = (median < int'(FLOOR_MIN)) ? int'(FLOOR_MIN) : median;
                  r.block_published = 1'b1;
               end
            end
         end
         ACT_RECAL: begin
            if (count_q >= SAMPLES_PER_BLOCK && consumed_q) begin
               count_q = 0;
               consumed_q = 1'b0;
            end
         end
         ACT_AGC_RESET: begin
            if (!t.irq_pending && !t.packet_in_progress) begin
               count_q = 0;
               consumed_q = 1'b0;
               held_q = '0;
            end
         end
         default: ;
      endcase
      r.channel_busy = (cfg_q.interference_threshold != 0) &&
                       (rssi > floor_q + int'(cfg_q.interference_threshold));
      r.floor_dbm = floor_q[8:0];
      r.samples_in_block = count_q[6:0];
      return r;
   endfunction

   function automatic item_type make_tick();
      item_type t;
      int       pick;
      int       v;
      t = '0;
      pick = $urandom_range(0, 99);
      if (count_q == 0) begin
         // new block: mostly near the floor range, sometimes anywhere
         if ($urandom_range(0, 11) == 0) block_level = int'($urandom_range(0, 499)) - 256;
         else block_level = int'($urandom_range(0, 100)) - 130;
         block_spread = $urandom_range(0, 12);
      end
      if ($urandom_range(0, 24) == 0) v = $urandom_range(0, 511);
      else v = block_level + int'($urandom_range(0, block_spread));
      t.rssi_dbm = v[8:0];
      t.radio_in_rx = 1'b1;
      t.packet_in_progress = ($urandom_range(0, 19) == 0);
      t.irq_pending = ($urandom_range(0, 9) == 0);
      if (count_q < SAMPLES_PER_BLOCK) begin
         if (pick < 93) begin
            t.action = ACT_SAMPLE;
            t.radio_in_rx = ($urandom_range(0, 19) != 0);
         end else if (pick < 95) t.action = ACT_RECAL;
         else if (pick < 96) t.action = ACT_AGC_RESET;
         else t.action = ACT_NONE;
      end else if (!consumed_q) begin
         if (pick < 70) begin
            t.action = ACT_SAMPLE;
            t.radio_in_rx = 1'($urandom_range(0, 1));
         end else if (pick < 82) t.action = ACT_RECAL;
         else if (pick < 86) t.action = ACT_AGC_RESET;
         else t.action = ACT_NONE;
      end else begin
         if (pick < 60) t.action = ACT_RECAL;
         else if (pick < 85) t.action = ACT_SAMPLE;
         else if (pick < 90) t.action = ACT_AGC_RESET;
         else t.action = ACT_NONE;
      end
      pick = $urandom_range(0, 99);
      if (pick < 80)
         clock_ms = clock_ms + cfg_q.sample_interval_ms + $urandom_range(0, 40);
      else if (pick < 96)
         clock_ms = clock_ms + $urandom_range(0, cfg_q.sample_interval_ms);
      else
         clock_ms = $urandom;
      t.now_ms = clock_ms;
      return t;
   endfunction

   task automatic add_row(action_type a, logic [31:0] now, int rssi, bit rx, bit pkt,
                          bit irq, bit typed, int flr, bit tk, bit pb, bit hd, bit bz,
                          int cnt);
      dir_row_type row;
      row = '0;
      row.tick.action = a;
      row.tick.now_ms = now;
      row.tick.rssi_dbm = rssi[8:0];
      row.tick.radio_in_rx = rx;
      row.tick.packet_in_progress = pkt;
      row.tick.irq_pending = irq;
      row.typed = typed;
      row.want.floor_dbm = flr[8:0];
      row.want.sample_taken = tk;
      row.want.block_published = pb;
      row.want.block_held = hd;
      row.want.channel_busy = bz;
      row.want.samples_in_block = cnt[6:0];
      dir_rows.push_back(row);
   endtask

   // entered and left at a falling edge; valid stays high for a back-to-back beat
   task automatic send_tick(item_type t, bit typed, floor_rsp_type want);
      int            gap;
      floor_rsp_type pred;
      gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.action = t.action;
      req_ch.now_ms = t.now_ms;
      req_ch.rssi_dbm = t.rssi_dbm;
      req_ch.radio_in_rx = t.radio_in_rx;
      req_ch.packet_in_progress = t.packet_in_progress;
      req_ch.irq_pending = t.irq_pending;
      do @(posedge clock); while (!req_ch.ready);
      pred = predict_floor_result(t);
      pending_results.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic drain(int extra);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_cfg(cfg_type c);
      reg_index_type idx;
      logic [15:0]   wd;
      for (int k = 0; k <= int'(REG_INTERVAL); k++) begin
         idx = reg_index_type'(k);
         // bits above the register width are junk and must be dropped
         wd = 16'($urandom);
         case (idx)
            REG_THRESHOLD: wd[6:0] = c.interference_threshold;
            REG_MAX_RISE:  wd[6:0] = c.max_rise_db;
            REG_MAX_HELD:  wd[3:0] = c.max_held_blocks;
            default:       wd = c.sample_interval_ms;
         endcase
         csr_ch.valid = 1'b1;
         csr_ch.index = idx;
         csr_ch.wdata = wd;
         do @(posedge clock); while (!csr_ch.ready);
         case (idx)
            REG_THRESHOLD: cfg_q.interference_threshold = wd[6:0];
            REG_MAX_RISE:  cfg_q.max_rise_db = wd[6:0];
            REG_MAX_HELD:  cfg_q.max_held_blocks = wd[3:0];
            default:       cfg_q.sample_interval_ms = wd;
         endcase
         @(negedge clock);
      end
      csr_ch.valid = 1'b0;
   endtask

   task automatic run_random(int n, bit pause_mid);
      item_type t;
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (pause_mid && i == n / 2) drain(0);
         t = make_tick();
         send_tick(t, 1'b0, '0);
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      if (err_cnt < 100)
         $display("mismatch on result %0d: %s got %0d expected %0d", rsp_idx, what, got, want);
      err_cnt++;
   endtask

   // response side: random stall per beat, check at the accepting edge
   initial begin : rsp_side
      int            stall;
      floor_rsp_type want;
      rsp_ch.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing expected", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.floor_dbm !== want.floor_dbm)
               report_mismatch("floor_dbm", int'(rsp_ch.floor_dbm), int'(want.floor_dbm));
            if (rsp_ch.sample_taken !== want.sample_taken)
               report_mismatch("sample_taken", int'(rsp_ch.sample_taken),
                               int'(want.sample_taken));
            if (rsp_ch.block_published !== want.block_published)
               report_mismatch("block_published", int'(rsp_ch.block_published),
                               int'(want.block_published));
            if (rsp_ch.block_held !== want.block_held)
               report_mismatch("block_held", int'(rsp_ch.block_held), int'(want.block_held));
            if (rsp_ch.channel_busy !== want.channel_busy)
               report_mismatch("channel_busy", int'(rsp_ch.channel_busy),
                               int'(want.channel_busy));
            if (rsp_ch.samples_in_block !== want.samples_in_block)
               report_mismatch("samples_in_block", int'(rsp_ch.samples_in_block),
                               int'(want.samples_in_block));
         end
         rsp_idx++;
         @(negedge clock);
      end
   end

   // no beat on any channel for too long ends the run
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : main
      cfg_type     phase_cfg [NUM_PHASES];
      dir_row_type row;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_NONE;
      req_ch.now_ms = '0;
      req_ch.rssi_dbm = '0;
      req_ch.radio_in_rx = 1'b0;
      req_ch.packet_in_progress = 1'b0;
      req_ch.irq_pending = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_THRESHOLD;
      csr_ch.wdata = '0;
      reset = 1'b1;
      quiet = 1'b0;
      cfg_q.interference_threshold = 7'd0;
      cfg_q.max_rise_db = 7'd10;
      cfg_q.max_held_blocks = 4'd4;
      cfg_q.sample_interval_ms = 16'd100;
      count_q = 0;
      consumed_q = 1'b0;
      floor_q = 0;
      held_q = '0;
      last_ms_q = '0;
      block_level = -100;
      block_spread = 4;

      phase_cfg[0] = cfg_q;
      phase_cfg[1] = '{7'd127, 7'd0, 4'd15, 16'd0};
      phase_cfg[2] = '{7'd1, 7'd127, 4'd1, 16'd65535};
      phase_cfg[3] = '{7'd20, 7'd5, 4'd0, 16'd1};
      phase_cfg[4] = '{7'd0, 7'd10, 4'd2, 16'($urandom)};
      phase_cfg[5] = '{7'($urandom_range(1, 127)), 7'($urandom_range(0, 127)),
                       4'($urandom_range(1, 15)), 16'($urandom_range(0, 300))};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // act,now,rssi,rx,pkt,irq | typed | floor,taken,pub,held,busy,count
      add_row(ACT_NONE,      32'h0,        0,    0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_RECAL,     32'h0,        -1,   1, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_AGC_RESET, 32'h0,        0,    1, 0, 1, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_SAMPLE,    32'd10,       -50,  0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_SAMPLE,    32'd20,       -50,  1, 1, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_SAMPLE,    32'd5,        -256, 1, 0, 0, 1, 0, 1, 0, 0, 0, 1);
      add_row(ACT_SAMPLE,    32'd50,       255,  1, 0, 0, 1, 0, 0, 0, 0, 0, 1);
      add_row(ACT_SAMPLE,    32'd105,      255,  1, 0, 0, 1, 0, 1, 0, 0, 0, 2);
      // elapsed time across the 32-bit wrap
      add_row(ACT_SAMPLE,    32'hFFFF_FFF0, -120, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_SAMPLE,    32'h0000_0050, 0,    1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_SAMPLE,    32'h0000_0054, 0,    1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_NONE,      32'h0000_0060, 17,   1, 1, 1, 1, 0, 0, 0, 0, 0, 4);
      add_row(ACT_AGC_RESET, 32'h0000_0070, 0,    1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_RECAL,     32'h0000_0080, 0,    1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_AGC_RESET, 32'h0000_0090, 0,    0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_SAMPLE,    32'h0000_0091, -1,   1, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_SAMPLE,    32'h0000_0095, 100,  1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      while (dir_rows.size() != 0) begin
         row = dir_rows.pop_front();
         send_tick(row.tick, row.typed, row.want);
      end

      clock_ms = 32'h0000_0200;
      run_random(TICKS_PER_PHASE, 1'b0);
      for (int p = 1; p < NUM_PHASES; p++) begin
         drain(4);
         write_cfg(phase_cfg[p]);
         run_random(TICKS_PER_PHASE, p == 2);
      end

      drain(8);
      if (err_cnt == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
design/rnf_pkg.sv
design/rnf_if.sv
design/rnf_csr.sv
design/rnf_sort_cell.sv
design/rssi_noise_floor_median_core.sv
tb/rssi_noise_floor_median_core_tb.sv
